FILE: src/xrt_pkg.sv
package xrt_pkg;

  localparam int unsigned NumSlots = 3;

  localparam logic [1:0] KIND_CONTENT = 2'd0;
  localparam logic [1:0] KIND_TAG     = 2'd1;
  localparam logic [1:0] KIND_ATTR    = 2'd2;
  localparam logic [1:0] KIND_VALUE   = 2'd3;

  localparam logic [3:0] REC_NONE    = 4'd0;
  localparam logic [3:0] REC_HEADER  = 4'd1;
  localparam logic [3:0] REC_DOCTYPE = 4'd2;
  localparam logic [3:0] REC_COMMENT = 4'd3;
  localparam logic [3:0] REC_CDATA   = 4'd4;
  localparam logic [3:0] REC_TEXT    = 4'd5;
  localparam logic [3:0] REC_START   = 4'd6;
  localparam logic [3:0] REC_FULL    = 4'd7;
  localparam logic [3:0] REC_END     = 4'd8;
  localparam logic [3:0] REC_EOF     = 4'd9;
  localparam logic [3:0] REC_ERROR   = 4'd10;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_MARKUP      = 4'd1;
  localparam logic [3:0] ERR_HEADER_GT   = 4'd2;
  localparam logic [3:0] ERR_DOCTYPE_GT  = 4'd3;
  localparam logic [3:0] ERR_COMMENT_GT  = 4'd4;
  localparam logic [3:0] ERR_CDATA_RB    = 4'd5;
  localparam logic [3:0] ERR_TAG_NAME    = 4'd6;
  localparam logic [3:0] ERR_ATTR_NAME   = 4'd7;
  localparam logic [3:0] ERR_SLASH       = 4'd8;
  localparam logic [3:0] ERR_EQUAL       = 4'd9;
  localparam logic [3:0] ERR_VALUE       = 4'd10;
  localparam logic [3:0] ERR_EARLY_END   = 4'd11;
  localparam logic [3:0] ERR_CDATA_END   = 4'd12;

  localparam logic [2:0] KwLen = 3'd7;

  typedef enum logic [21:0] {
    S_WAIT        = 22'd1 << 0,
    S_TEXT        = 22'd1 << 1,
    S_LT          = 22'd1 << 2,
    S_BANG        = 22'd1 << 3,
    S_BANG_DASH   = 22'd1 << 4,
    S_KW_DOC      = 22'd1 << 5,
    S_KW_CDATA    = 22'd1 << 6,
    S_HEADER      = 22'd1 << 7,
    S_HEADER_Q    = 22'd1 << 8,
    S_DOCTYPE     = 22'd1 << 9,
    S_DOCMARKUP   = 22'd1 << 10,
    S_DOCMARKUP_RB= 22'd1 << 11,
    S_COMMENT     = 22'd1 << 12,
    S_CDATA       = 22'd1 << 13,
    S_ENDTAG      = 22'd1 << 14,
    S_TAGNAME     = 22'd1 << 15,
    S_ATTR_WAIT   = 22'd1 << 16,
    S_ATTR_NAME   = 22'd1 << 17,
    S_EQUAL       = 22'd1 << 18,
    S_VALUE_WAIT  = 22'd1 << 19,
    S_VALUE       = 22'd1 << 20,
    S_SLASH       = 22'd1 << 21
  } pstate_t;

  typedef struct packed {
    pstate_t    state;
    logic [2:0] kw_pos;
    logic [1:0] held;
    logic [7:0] quote;
  } pctx_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       valid;
    logic       rec_end;
    logic [3:0] rtype;
    logic [3:0] err;
  } result_t;

  function automatic logic [7:0] kw_doctype(input logic [2:0] i);
    unique case (i)
      3'd0: return "D";
      3'd1: return "O";
      3'd2: return "C";
      3'd3: return "T";
      3'd4: return "Y";
      3'd5: return "P";
      3'd6: return "E";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_cdata(input logic [2:0] i);
    unique case (i)
      3'd0: return "[";
      3'd1: return "C";
      3'd2: return "D";
      3'd3: return "A";
      3'd4: return "T";
      3'd5: return "A";
      3'd6: return "[";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic name_start(input logic [7:0] b);
    return is_alpha(b) || b == "_" || b == ":";
  endfunction

  function automatic logic name_char(input logic [7:0] b);
    return is_alpha(b) || (b >= "0" && b <= "9") || b == "." || b == "-" ||
           b == "_" || b == ":";
  endfunction

  function automatic logic name_term(input logic [7:0] b);
    return is_blank(b) || b == "=" || b == 8'h00 || b == "/" || b == ">";
  endfunction

endpackage

FILE: src/xrt_step.sv
module xrt_step
  import xrt_pkg::*;
(
  input  pctx_t                     ctx,
  input  logic [7:0]                b,
  input  logic                      eot,
  output pctx_t                     ctx_nxt,
  output result_t [NumSlots-1:0]    res,
  output logic [1:0]                res_cnt
);

  localparam pctx_t CtxIdle = '{state: S_WAIT, kw_pos: 3'd0, held: 2'd0, quote: 8'h00};

  function automatic result_t mk(input logic [1:0] kind, input logic [7:0] data,
                                 input logic valid, input logic rec_end,
                                 input logic [3:0] rtype, input logic [3:0] err);
    result_t r;
    r.kind    = kind;
    r.data    = valid ? data : 8'h00;
    r.valid   = valid;
    r.rec_end = rec_end;
    r.rtype   = rtype;
    r.err     = err;
    return r;
  endfunction

  always_comb begin
    ctx_nxt = ctx;
    res     = '0;
    res_cnt = 2'd0;
    if (eot) begin
      if (ctx.state == S_WAIT) res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_EOF, ERR_NONE);
      else res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_EARLY_END);
      res_cnt = 2'd1;
      ctx_nxt = CtxIdle;
    end else begin
      unique case (ctx.state)
        S_TEXT: begin
          if (b == "<") begin
            res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_TEXT, ERR_NONE);
            res_cnt = 2'd1;
            ctx_nxt = CtxIdle;
            ctx_nxt.state = S_LT;
          end else begin
            res[0] = mk(KIND_CONTENT, b, 1'b1, 1'b0, REC_NONE, ERR_NONE);
            res_cnt = 2'd1;
          end
        end
        S_LT: begin
          if (b == "?") ctx_nxt.state = S_HEADER;
          else if (b == "/") ctx_nxt.state = S_ENDTAG;
          else if (b == "!") ctx_nxt.state = S_BANG;
          else if (name_start(b)) begin
            res[0] = mk(KIND_TAG, b, 1'b1, 1'b0, REC_NONE, ERR_NONE);
            res_cnt = 2'd1;
            ctx_nxt.state = S_TAGNAME;
          end else begin
            res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_MARKUP);
            res_cnt = 2'd1;
            ctx_nxt = CtxIdle;
          end
        end
        S_BANG: begin
          if (b == "-") ctx_nxt.state = S_BANG_DASH;
          else if (b == "D") begin
            ctx_nxt.state = S_KW_DOC;
            ctx_nxt.kw_pos = 3'd1;
          end else if (b == "[") begin
            ctx_nxt.state = S_KW_CDATA;
            ctx_nxt.kw_pos = 3'd1;
          end else begin
            res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_MARKUP);
            res_cnt = 2'd1;
            ctx_nxt = CtxIdle;
          end
        end
        S_BANG_DASH: begin
          if (b == "-") begin
            ctx_nxt.state = S_COMMENT;
            ctx_nxt.held = 2'd0;
          end else begin
            res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_MARKUP);
            res_cnt = 2'd1;
            ctx_nxt = CtxIdle;
          end
        end
        S_KW_DOC: begin
          if (ctx.kw_pos < KwLen && b == kw_doctype(ctx.kw_pos)) begin
            ctx_nxt.kw_pos = ctx.kw_pos + 3'd1;
          end else if (ctx.kw_pos == KwLen && is_blank(b)) begin
            ctx_nxt.state = S_DOCTYPE;
            ctx_nxt.kw_pos = 3'd0;
          end else begin
            res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_MARKUP);
            res_cnt = 2'd1;
            ctx_nxt = CtxIdle;
          end
        end
        S_KW_CDATA: begin
          if (ctx.kw_pos < KwLen && b == kw_cdata(ctx.kw_pos)) begin
            ctx_nxt.kw_pos = ctx.kw_pos + 3'd1;
            if (ctx.kw_pos == KwLen - 3'd1) begin
              ctx_nxt.state = S_CDATA;
              ctx_nxt.kw_pos = 3'd0;
              ctx_nxt.held = 2'd0;
            end
          end else begin
            res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_MARKUP);
            res_cnt = 2'd1;
            ctx_nxt = CtxIdle;
          end
        end
        S_HEADER: begin
          if (b == "?") ctx_nxt.state = S_HEADER_Q;
          else begin
            res[0] = mk(KIND_CONTENT, b, 1'b1, 1'b0, REC_NONE, ERR_NONE);
            res_cnt = 2'd1;
          end
        end
        S_HEADER_Q: begin
          if (b == ">") res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_HEADER, ERR_NONE);
          else res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_HEADER_GT);
          res_cnt = 2'd1;
          ctx_nxt = CtxIdle;
        end
        S_DOCTYPE: begin
          res_cnt = 2'd1;
          if (b == "[") begin
            res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_NONE, ERR_NONE);
            ctx_nxt.state = S_DOCMARKUP;
          end else if (b == ">") begin
            res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_DOCTYPE, ERR_NONE);
            ctx_nxt = CtxIdle;
          end else begin
            res[0] = mk(KIND_CONTENT, b, 1'b1, 1'b0, REC_NONE, ERR_NONE);
          end
        end
        S_DOCMARKUP: begin
          if (b == "]") ctx_nxt.state = S_DOCMARKUP_RB;
          else begin
            res[0] = mk(KIND_CONTENT, b, 1'b1, 1'b0, REC_NONE, ERR_NONE);
            res_cnt = 2'd1;
          end
        end
        S_DOCMARKUP_RB: begin
          if (b == ">") res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_DOCTYPE, ERR_NONE);
          else res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_DOCTYPE_GT);
          res_cnt = 2'd1;
          ctx_nxt = CtxIdle;
        end
        S_COMMENT: begin
          if (ctx.held >= 2'd2) begin
            if (b == ">") res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_COMMENT, ERR_NONE);
            else res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_COMMENT_GT);
            res_cnt = 2'd1;
            ctx_nxt = CtxIdle;
          end else if (ctx.held == 2'd1) begin
            if (b == "-") ctx_nxt.held = 2'd2;
            else begin
              // release the held dash ahead of this byte
              res[0] = mk(KIND_CONTENT, "-", 1'b1, 1'b0, REC_NONE, ERR_NONE);
              res[1] = mk(KIND_CONTENT, b, 1'b1, 1'b0, REC_NONE, ERR_NONE);
              res_cnt = 2'd2;
              ctx_nxt.held = 2'd0;
            end
          end else if (b == "-") ctx_nxt.held = 2'd1;
          else begin
            res[0] = mk(KIND_CONTENT, b, 1'b1, 1'b0, REC_NONE, ERR_NONE);
            res_cnt = 2'd1;
          end
        end
        S_CDATA: begin
          if (ctx.held >= 2'd2) begin
            if (b == ">") res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_CDATA, ERR_NONE);
            else res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_CDATA_END);
            res_cnt = 2'd1;
            ctx_nxt = CtxIdle;
          end else if (ctx.held == 2'd1) begin
            if (b == "]") ctx_nxt.held = 2'd2;
            else begin
              res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_CDATA_RB);
              res_cnt = 2'd1;
              ctx_nxt = CtxIdle;
            end
          end else if (b == "]") ctx_nxt.held = 2'd1;
          else begin
            res[0] = mk(KIND_CONTENT, b, 1'b1, 1'b0, REC_NONE, ERR_NONE);
            res_cnt = 2'd1;
          end
        end
        S_ENDTAG: begin
          res_cnt = 2'd1;
          if (b == ">") begin
            res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_END, ERR_NONE);
            ctx_nxt = CtxIdle;
          end else res[0] = mk(KIND_TAG, b, 1'b1, 1'b0, REC_NONE, ERR_NONE);
        end
        S_TAGNAME, S_ATTR_WAIT: begin
          if (ctx.state == S_TAGNAME && name_char(b)) begin
            res[0] = mk(KIND_TAG, b, 1'b1, 1'b0, REC_NONE, ERR_NONE);
            res_cnt = 2'd1;
          end else if (ctx.state == S_TAGNAME && !name_term(b)) begin
            res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_TAG_NAME);
            res_cnt = 2'd1;
            ctx_nxt = CtxIdle;
          end else begin
            // a closing tag name emits its field close, then the byte is
            // taken as the first token after the name
            logic [1:0] k;
            k = (ctx.state == S_TAGNAME) ? 2'd1 : 2'd0;
            if (ctx.state == S_TAGNAME)
              res[0] = mk(KIND_TAG, 8'h00, 1'b0, 1'b1, REC_NONE, ERR_NONE);
            res_cnt = k;
            if (is_blank(b)) ctx_nxt.state = S_ATTR_WAIT;
            else if (b == "/") ctx_nxt.state = S_SLASH;
            else if (b == ">") begin
              res[k] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_START, ERR_NONE);
              res_cnt = k + 2'd1;
              ctx_nxt = CtxIdle;
            end else if (name_start(b)) begin
              res[k] = mk(KIND_ATTR, b, 1'b1, 1'b0, REC_NONE, ERR_NONE);
              res_cnt = k + 2'd1;
              ctx_nxt.state = S_ATTR_NAME;
            end else begin
              res[k] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_ATTR_NAME);
              res_cnt = k + 2'd1;
              ctx_nxt = CtxIdle;
            end
          end
        end
        S_ATTR_NAME: begin
          if (name_char(b)) begin
            res[0] = mk(KIND_ATTR, b, 1'b1, 1'b0, REC_NONE, ERR_NONE);
            res_cnt = 2'd1;
          end else if (name_term(b)) begin
            res[0] = mk(KIND_ATTR, 8'h00, 1'b0, 1'b1, REC_NONE, ERR_NONE);
            res_cnt = 2'd1;
            if (b == "=") ctx_nxt.state = S_VALUE_WAIT;
            else if (is_blank(b)) ctx_nxt.state = S_EQUAL;
            else begin
              res[1] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_EQUAL);
              res_cnt = 2'd2;
              ctx_nxt = CtxIdle;
            end
          end else begin
            res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_ATTR_NAME);
            res_cnt = 2'd1;
            ctx_nxt = CtxIdle;
          end
        end
        S_EQUAL: begin
          if (b == "=") ctx_nxt.state = S_VALUE_WAIT;
          else if (!is_blank(b)) begin
            res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_EQUAL);
            res_cnt = 2'd1;
            ctx_nxt = CtxIdle;
          end
        end
        S_VALUE_WAIT: begin
          if (b == 8'h22 || b == 8'h27) begin
            ctx_nxt.quote = b;
            ctx_nxt.state = S_VALUE;
          end else if (!is_blank(b)) begin
            res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_VALUE);
            res_cnt = 2'd1;
            ctx_nxt = CtxIdle;
          end
        end
        S_VALUE: begin
          res_cnt = 2'd1;
          if (b == ctx.quote) begin
            res[0] = mk(KIND_VALUE, 8'h00, 1'b0, 1'b1, REC_NONE, ERR_NONE);
            ctx_nxt.quote = 8'h00;
            ctx_nxt.state = S_ATTR_WAIT;
          end else res[0] = mk(KIND_VALUE, b, 1'b1, 1'b0, REC_NONE, ERR_NONE);
        end
        S_SLASH: begin
          if (b == ">") res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_FULL, ERR_NONE);
          else res[0] = mk(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, ERR_SLASH);
          res_cnt = 2'd1;
          ctx_nxt = CtxIdle;
        end
        default: begin
          // waiting: skip blanks, open markup or start text
          if (b == "<") ctx_nxt.state = S_LT;
          else if (!is_blank(b)) begin
            res[0] = mk(KIND_CONTENT, b, 1'b1, 1'b0, REC_NONE, ERR_NONE);
            res_cnt = 2'd1;
            ctx_nxt.state = S_TEXT;
          end
        end
      endcase
    end
  end

endmodule

FILE: src/xrt_resq.sv
module xrt_resq
  import xrt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  result_t [NumSlots-1:0] load_res,
  input  logic [1:0]             load_cnt,
  output logic                   can_load,
  output logic                   res_valid,
  input  logic                   res_ready,
  output result_t                res_head,
  output logic                   res_last
);

  result_t [NumSlots-1:0] slot_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] rd_inc;

  assign rd_inc    = {1'b0, rd_r} + 3'd1;
  assign res_valid = rd_r != cnt_r;
  assign res_last  = rd_inc == {1'b0, cnt_r};
  assign res_head  = slot_r[rd_r];
  // free once the final result of the current item goes out
  assign can_load  = !res_valid || (res_ready && res_last);

  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    if (res_valid && res_ready) rd_nxt = rd_inc[1:0];
    if (load) begin
      cnt_nxt = load_cnt;
      rd_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
    end
    if (load) slot_r <= load_res;
  end

endmodule

FILE: src/xml_record_tokenizer_core.sv
// XML record tokenizer.
// Input channel: in_byte / in_end_of_text with in_valid / in_ready; one text
// byte per transfer, in_end_of_text marks the end of the document.
// Result channel: out_* fields with out_valid / out_ready. Each byte gives
// zero, one or two results (content bytes tagged by kind, field closes,
// record closes, error codes); out_last_result flags the final one.
// Latency: the first result of a byte appears on the cycle after its
// transfer. Throughput: one byte per cycle while each byte yields at most
// one result and the receiver takes each result; the single result register
// drains one result per transfer, so a byte with two results holds the
// input until both are taken. Bytes that give no result pass at one per cycle.
// Reset (rst_n low, synchronous) returns the parser to waiting for markup
// or text and empties the result register.
// When the receiver stalls, results hold in the result register and
// in_ready drops once the current byte's results are not all taken.
module xml_record_tokenizer_core
  import xrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_data_kind,
  output logic [7:0] out_data_byte,
  output logic       out_byte_valid,
  output logic       out_record_end,
  output logic [3:0] out_record_type,
  output logic [3:0] out_error_code,
  output logic       out_last_result
);

  pctx_t ctx_r, ctx_nxt;
  result_t [NumSlots-1:0] step_res;
  logic [1:0] step_cnt;
  logic in_xfer;
  result_t head;

  assign in_xfer = in_valid && in_ready;

  // one parser transition per accepted byte
  xrt_step u_step (
    .ctx     (ctx_r),
    .b       (in_byte),
    .eot     (in_end_of_text),
    .ctx_nxt (ctx_nxt),
    .res     (step_res),
    .res_cnt (step_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '{state: S_WAIT, kw_pos: 3'd0, held: 2'd0, quote: 8'h00};
    end else if (in_xfer) begin
      ctx_r <= ctx_nxt;
    end
  end

  // result register: drain this byte's results one transfer at a time
  xrt_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_xfer),
    .load_res  (step_res),
    .load_cnt  (step_cnt),
    .can_load  (in_ready),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res_head  (head),
    .res_last  (out_last_result)
  );

  assign out_data_kind   = head.kind;
  assign out_data_byte   = head.data;
  assign out_byte_valid  = head.valid;
  assign out_record_end  = head.rec_end;
  assign out_record_type = head.rtype;
  assign out_error_code  = head.err;

`ifndef SYNTHESIS
  a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || (out_ready && out_last_result))
    else $error("byte taken while earlier results pending");
  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_valid || out_record_end)
    else $error("result carries neither byte nor close");
  a_err_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_error_code != ERR_NONE) == (out_record_type == REC_ERROR)))
    else $error("error code and record type disagree");
`endif

endmodule

FILE: dv/xml_record_tokenizer_core_test.sv
`timescale 1ns / 100ps

module xml_record_tokenizer_core_test;
  import xrt_pkg::*;

  // Parser phases of the predictor, one per step of the XML grammar walk
  typedef enum int {
    T_WAIT, T_TEXT, T_LT, T_BANG, T_BANG_DASH, T_KW_DOC, T_KW_CDATA,
    T_HEADER, T_HEADER_Q, T_DOCTYPE, T_DOCMARKUP, T_DOCMARKUP_RB,
    T_COMMENT, T_CDATA, T_ENDTAG, T_TAGNAME, T_ATTR_WAIT, T_ATTR_NAME,
    T_EQUAL, T_VALUE_WAIT, T_VALUE, T_SLASH
  } tok_phase_e;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic       valid;
    logic       rend;
    logic [3:0] rtype;
    logic [3:0] err;
    logic       last;
  } token_t;

  typedef struct {
    logic       eot;
    logic [7:0] b;
  } xml_byte_t;

  typedef struct {
    logic       eot;
    logic [7:0] b;
    logic       chk;
    logic [3:0] rtype;
    logic [3:0] err;
  } dir_row_t;

  localparam string KW_DOCTYPE = "DOCTYPE";
  localparam string KW_CDATA   = "[CDATA[";
  localparam int    HOLD_AT    = 150;
  localparam int    HOLD_LEN   = 200;
  localparam int    DRAIN_AT   = 250;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_data_kind;
  logic [7:0] out_data_byte;
  logic       out_byte_valid;
  logic       out_record_end;
  logic [3:0] out_record_type;
  logic [3:0] out_error_code;
  logic       out_last_result;

  xml_record_tokenizer_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_kind  (out_data_kind),
    .out_data_byte  (out_data_byte),
    .out_byte_valid (out_byte_valid),
    .out_record_end (out_record_end),
    .out_record_type(out_record_type),
    .out_error_code (out_error_code),
    .out_last_result(out_last_result)
  );

  always #6 clk = ~clk;

  // Predictor context
  tok_phase_e phase;
  int         kw_pos;
  logic [7:0] held_b;
  int         held_n;
  logic [7:0] quote_b;

  token_t     step_tokens[$];
  token_t     pending_tokens[$];
  xml_byte_t  text_bytes[$];

  int  mismatches = 0;
  int  sent = 0;
  bit  calm = 1'b0;
  bit  hold_done = 1'b0;

  // Table of directed bytes; expectations typed in only for rows that close a record or raise an error
  dir_row_t dir_rows[27] = '{
    '{1'b1, 8'h5A, 1'b1, REC_EOF,     ERR_NONE},
    '{1'b0, " ",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, 8'hFF, 1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, 8'h00, 1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, "<",   1'b1, REC_TEXT,    ERR_NONE},
    '{1'b0, "#",   1'b1, REC_ERROR,   ERR_MARKUP},
    '{1'b0, "<",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, "?",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, "x",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, "?",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, ">",   1'b1, REC_HEADER,  ERR_NONE},
    '{1'b0, "<",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, "a",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, "/",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, ">",   1'b1, REC_FULL,    ERR_NONE},
    '{1'b0, "<",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, "a",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b1, 8'hA5, 1'b1, REC_ERROR,   ERR_EARLY_END},
    '{1'b0, "<",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, "!",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, "-",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, "-",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, "-",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, "x",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, "-",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, "-",   1'b0, REC_NONE,    ERR_NONE},
    '{1'b0, ">",   1'b1, REC_COMMENT, ERR_NONE}
  };

  function automatic bit blank_b(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  function automatic bit letter_b(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic bit name_first_b(logic [7:0] b);
    return letter_b(b) || b == "_" || b == ":";
  endfunction

  function automatic bit name_more_b(logic [7:0] b);
    return name_first_b(b) || (b >= "0" && b <= "9") || b == "." || b == "-";
  endfunction

  function automatic bit name_stop_b(logic [7:0] b);
    return blank_b(b) || b == "=" || b == 8'h00 || b == "/" || b == ">";
  endfunction

  function automatic void emit_token(logic [1:0] kind, logic [7:0] data, logic valid,
                                     logic rend, logic [3:0] rtype, logic [3:0] err);
    token_t t;
    t.kind = kind;
    t.data = valid ? data : 8'h00;
    t.valid = valid;
    t.rend = rend;
    t.rtype = rtype;
    t.err = err;
    t.last = 1'b0;
    if (step_tokens.size() < NumSlots) step_tokens.push_back(t);
  endfunction

  function automatic void emit_byte(logic [1:0] kind, logic [7:0] b);
    emit_token(kind, b, 1'b1, 1'b0, REC_NONE, ERR_NONE);
  endfunction

  function automatic void reset_ctx();
    phase = T_WAIT;
    kw_pos = 0;
    held_b = 8'h00;
    held_n = 0;
    quote_b = 8'h00;
  endfunction

  function automatic void raise_error(logic [3:0] code);
    emit_token(KIND_CONTENT, 8'h00, 1'b0, 1'b1, REC_ERROR, code);
    reset_ctx();
  endfunction

  function automatic void close_record(logic [3:0] rtype);
    emit_token(KIND_CONTENT, 8'h00, 1'b0, 1'b1, rtype, ERR_NONE);
    reset_ctx();
  endfunction

  function automatic void close_field(logic [1:0] kind);
    emit_token(kind, 8'h00, 1'b0, 1'b1, REC_NONE, ERR_NONE);
  endfunction

  function automatic void between_attrs(logic [7:0] b);
    if (blank_b(b)) phase = T_ATTR_WAIT;
    else if (b == "/") phase = T_SLASH;
    else if (b == ">") close_record(REC_START);
    else if (name_first_b(b)) begin
      emit_byte(KIND_ATTR, b);
      phase = T_ATTR_NAME;
    end else raise_error(ERR_ATTR_NAME);
  endfunction

  // Advance the parser by one byte and queue the tokens it yields
  function automatic void tokenize_byte(logic [7:0] b, logic eot);
    step_tokens.delete();
    if (eot) begin
      if (phase == T_WAIT) close_record(REC_EOF);
      else raise_error(ERR_EARLY_END);
    end else begin
      case (phase)
        T_TEXT: begin
          if (b == "<") begin
            close_record(REC_TEXT);
            phase = T_LT;
          end else emit_byte(KIND_CONTENT, b);
        end
        T_LT: begin
          if (b == "?") phase = T_HEADER;
          else if (b == "/") phase = T_ENDTAG;
          else if (b == "!") phase = T_BANG;
          else if (name_first_b(b)) begin
            emit_byte(KIND_TAG, b);
            phase = T_TAGNAME;
          end else raise_error(ERR_MARKUP);
        end
        T_BANG: begin
          if (b == "-") phase = T_BANG_DASH;
          else if (b == "D") begin
            phase = T_KW_DOC;
            kw_pos = 1;
          end else if (b == "[") begin
            phase = T_KW_CDATA;
            kw_pos = 1;
          end else raise_error(ERR_MARKUP);
        end
        T_BANG_DASH: begin
          if (b == "-") begin
            phase = T_COMMENT;
            held_n = 0;
          end else raise_error(ERR_MARKUP);
        end
        T_KW_DOC: begin
          if (kw_pos < 7) begin
            if (b == KW_DOCTYPE[kw_pos]) kw_pos++;
            else raise_error(ERR_MARKUP);
          end else if (blank_b(b)) begin
            phase = T_DOCTYPE;
            kw_pos = 0;
          end else raise_error(ERR_MARKUP);
        end
        T_KW_CDATA: begin
          if (kw_pos < 7 && b == KW_CDATA[kw_pos]) begin
            kw_pos++;
            if (kw_pos == 7) begin
              phase = T_CDATA;
              kw_pos = 0;
              held_n = 0;
            end
          end else raise_error(ERR_MARKUP);
        end
        T_HEADER: begin
          if (b == "?") phase = T_HEADER_Q;
          else emit_byte(KIND_CONTENT, b);
        end
        T_HEADER_Q: begin
          if (b == ">") close_record(REC_HEADER);
          else raise_error(ERR_HEADER_GT);
        end
        T_DOCTYPE: begin
          // '[' splits the name part from the internal subset
          if (b == "[") begin
            close_field(KIND_CONTENT);
            phase = T_DOCMARKUP;
          end else if (b == ">") close_record(REC_DOCTYPE);
          else emit_byte(KIND_CONTENT, b);
        end
        T_DOCMARKUP: begin
          if (b == "]") phase = T_DOCMARKUP_RB;
          else emit_byte(KIND_CONTENT, b);
        end
        T_DOCMARKUP_RB: begin
          if (b == ">") close_record(REC_DOCTYPE);
          else raise_error(ERR_DOCTYPE_GT);
        end
        T_COMMENT: begin
          // a lone dash is held back and released with the byte after it
          if (held_n >= 2) begin
            if (b == ">") close_record(REC_COMMENT);
            else raise_error(ERR_COMMENT_GT);
          end else if (held_n == 1) begin
            if (b == "-") held_n = 2;
            else begin
              emit_byte(KIND_CONTENT, held_b);
              emit_byte(KIND_CONTENT, b);
              held_n = 0;
              held_b = 8'h00;
            end
          end else if (b == "-") begin
            held_n = 1;
            held_b = "-";
          end else emit_byte(KIND_CONTENT, b);
        end
        T_CDATA: begin
          if (held_n >= 2) begin
            if (b == ">") close_record(REC_CDATA);
            else raise_error(ERR_CDATA_END);
          end else if (held_n == 1) begin
            if (b == "]") held_n = 2;
            else raise_error(ERR_CDATA_RB);
          end else if (b == "]") begin
            held_n = 1;
            held_b = "]";
          end else emit_byte(KIND_CONTENT, b);
        end
        T_ENDTAG: begin
          if (b == ">") close_record(REC_END);
          else emit_byte(KIND_TAG, b);
        end
        T_TAGNAME: begin
          if (name_more_b(b)) emit_byte(KIND_TAG, b);
          else if (name_stop_b(b)) begin
            close_field(KIND_TAG);
            between_attrs(b);
          end else raise_error(ERR_TAG_NAME);
        end
        T_ATTR_WAIT: between_attrs(b);
        T_ATTR_NAME: begin
          if (name_more_b(b)) emit_byte(KIND_ATTR, b);
          else if (name_stop_b(b)) begin
            close_field(KIND_ATTR);
            if (b == "=") phase = T_VALUE_WAIT;
            else if (blank_b(b)) phase = T_EQUAL;
            else raise_error(ERR_EQUAL);
          end else raise_error(ERR_ATTR_NAME);
        end
        T_EQUAL: begin
          if (b == "=") phase = T_VALUE_WAIT;
          else if (!blank_b(b)) raise_error(ERR_EQUAL);
        end
        T_VALUE_WAIT: begin
          if (b == 8'h22 || b == 8'h27) begin
            quote_b = b;
            phase = T_VALUE;
          end else if (!blank_b(b)) raise_error(ERR_VALUE);
        end
        T_VALUE: begin
          if (b == quote_b) begin
            close_field(KIND_VALUE);
            quote_b = 8'h00;
            phase = T_ATTR_WAIT;
          end else emit_byte(KIND_VALUE, b);
        end
        T_SLASH: begin
          if (b == ">") close_record(REC_FULL);
          else raise_error(ERR_SLASH);
        end
        default: begin
          if (b == "<") phase = T_LT;
          else if (!blank_b(b)) begin
            emit_byte(KIND_CONTENT, b);
            phase = T_TEXT;
          end
        end
      endcase
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  task automatic check_field(string what, int got, int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Stimulus building
  function automatic void push_byte(logic [7:0] b);
    xml_byte_t x;
    x.eot = 1'b0;
    x.b = b;
    text_bytes.push_back(x);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_eot();
    xml_byte_t x;
    x.eot = 1'b1;
    x.b = 8'($urandom_range(0, 255));
    text_bytes.push_back(x);
  endfunction

  // Random content byte, avoiding '<' and the markup bytes that would end the field
  function automatic logic [7:0] content_b(logic [7:0] stop_a, logic [7:0] stop_b);
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 7) == 0) b = 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(32, 126));
    end while (b == stop_a || b == stop_b || b == "<");
    return b;
  endfunction

  function automatic void push_name(int n);
    string first_set = "abcXYZ_:";
    string more_set = "az09.-_:QM";
    push_byte(first_set[$urandom_range(0, first_set.len() - 1)]);
    for (int i = 1; i < n; i++) push_byte(more_set[$urandom_range(0, more_set.len() - 1)]);
  endfunction

  function automatic void push_blanks();
    string blanks = " \t\n\r";
    repeat ($urandom_range(1, 2)) push_byte(blanks[$urandom_range(0, 3)]);
  endfunction

  function automatic void push_record();
    int start = text_bytes.size();
    logic [7:0] q;
    case ($urandom_range(0, 9))
      0: repeat ($urandom_range(1, 6)) push_byte(content_b("<", "<"));
      1: begin
        push_str("<?");
        repeat ($urandom_range(0, 5)) push_byte(content_b("?", "?"));
        push_str("?>");
      end
      2: begin
        push_str("<!DOCTYPE ");
        push_name($urandom_range(1, 4));
        if ($urandom_range(0, 1)) begin
          push_byte("[");
          repeat ($urandom_range(0, 5)) push_byte(content_b("]", "]"));
          push_byte("]");
        end
        push_byte(">");
      end
      3: begin
        push_str("<!--");
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 3) == 0) push_byte("-");
          push_byte(content_b("-", "-"));
        end
        push_str("-->");
      end
      4: begin
        push_str("<![CDATA[");
        repeat ($urandom_range(0, 6)) push_byte(content_b("]", "]"));
        push_str("]]>");
      end
      5, 6: begin
        push_byte("<");
        push_name($urandom_range(1, 4));
        repeat ($urandom_range(0, 2)) begin
          push_blanks();
          push_name($urandom_range(1, 3));
          if ($urandom_range(0, 1)) push_blanks();
          push_byte("=");
          if ($urandom_range(0, 1)) push_blanks();
          q = $urandom_range(0, 1) ? 8'h22 : 8'h27;
          push_byte(q);
          repeat ($urandom_range(0, 4)) push_byte(content_b(q, q));
          push_byte(q);
        end
        if ($urandom_range(0, 1)) push_blanks();
        if ($urandom_range(0, 1)) push_str("/>");
        else push_byte(">");
      end
      7: begin
        push_str("</");
        push_name($urandom_range(1, 4));
        push_byte(">");
      end
      8: push_blanks();
      default: begin
        // noise: raw bytes, sometimes followed by an early end of text
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) push_eot();
      end
    endcase
    // break roughly one record in ten by overwriting one of its bytes
    if (text_bytes.size() > start && $urandom_range(0, 9) == 0)
      text_bytes[$urandom_range(start, text_bytes.size() - 1)].b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 19) == 0) push_eot();
  endfunction

  task automatic send_byte(logic [7:0] b, logic eot);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
    if (sent == DRAIN_AT) begin
      // pause until the block has handed over every pending token
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending_tokens.size() != 0) @(posedge clk);
    end else if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    tokenize_byte(b, eot);
    sent++;
  endtask

  // Result side: random stalls, one long hold-off to back the block up
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && sent >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (calm) out_ready <= 1'b1;
      else if (stall_left > 0) stall_left--;
      else if ($urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 18);
      end else out_ready <= 1'b1;
    end
  end

  // Compare each transfer with the oldest pending token
  always @(posedge clk) begin
    token_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) report_mismatch("unexpected token", 1, 0);
      else begin
        want = pending_tokens.pop_front();
        check_field("data_kind", int'(out_data_kind), int'(want.kind));
        check_field("data_byte", int'(out_data_byte), int'(want.data));
        check_field("byte_valid", int'(out_byte_valid), int'(want.valid));
        check_field("record_end", int'(out_record_end), int'(want.rend));
        check_field("record_type", int'(out_record_type), int'(want.rtype));
        check_field("error_code", int'(out_error_code), int'(want.err));
        check_field("last_result", int'(out_last_result), int'(want.last));
      end
    end
  end

  initial begin
    #(12 * 200000);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int total;
    reset_ctx();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; hold each typed expectation against the last token
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, dir_rows[i].eot);
      if (dir_rows[i].chk) begin
        check_field("table record_type", int'(pending_tokens[$].rtype),
                    int'(dir_rows[i].rtype));
        check_field("table error_code", int'(pending_tokens[$].err),
                    int'(dir_rows[i].err));
      end
    end

    // Random documents, mostly well formed
    while (text_bytes.size() < 350) push_record();
    total = text_bytes.size();
    foreach (text_bytes[i]) begin
      if (i >= total - 60) calm = 1'b1;
      send_byte(text_bytes[i].b, text_bytes[i].eot);
    end
    in_valid <= 1'b0;
    calm = 1'b1;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
